/* src/srt_pkg.sv */
// shared types and status codes of the segment reassembly tracker
package srt_pkg;

   localparam int OFF_W = 32;
   localparam int LEN_W = 16;
   localparam int GAP_W = 32;

   localparam logic [2:0] STATUS_INSERTED = 3'd0;
   localparam logic [2:0] STATUS_REPLACED = 3'd1;
   localparam logic [2:0] STATUS_OVERLAP  = 3'd2;
   localparam logic [2:0] STATUS_BAD_CRC  = 3'd3;
   localparam logic [2:0] STATUS_FOREIGN  = 3'd4;
   localparam logic [2:0] STATUS_FULL     = 3'd5;
   localparam logic [2:0] STATUS_GAP      = 3'd6;
   localparam logic [2:0] STATUS_SCAN_END = 3'd7;

   localparam logic CSR_FILE_ID     = 1'b0;
   localparam logic CSR_FILE_ACTIVE = 1'b1;

   typedef struct packed {
      logic [OFF_W-1:0] off;
      logic [LEN_W-1:0] len;
   } entry_type;

   typedef enum logic [2:0] {
      CELL_HOLD    = 3'd0,
      CELL_LOAD    = 3'd1,
      CELL_SHIFT   = 3'd2,
      CELL_SET_LEN = 3'd3,
      CELL_ROTATE  = 3'd4
   } cell_action_type;

   typedef struct packed {
      cell_action_type action;
      logic            occupied;
   } cell_ctrl_type;

   typedef struct packed {
      logic hit;
      logic ahead;
      logic same;
   } cell_flags_type;

endpackage

/* src/srt_cell.sv */
// one table entry of the cell chain with its placement compare
module srt_cell
   import srt_pkg::*;
(
   input  logic           clock,
   input  cell_ctrl_type  ctrl,
   input  entry_type      seg,
   input  entry_type      prev_entry,
   input  entry_type      next_entry,
   output entry_type      entry,
   output cell_flags_type flags
);

   entry_type      entry_ff, entry_in;
   cell_flags_type flags_ff, flags_in;
   logic [OFF_W:0] e_end;
   logic [OFF_W:0] s_end;

   always_comb begin
      e_end = {1'b0, entry_ff.off} + {{(OFF_W-LEN_W+1){1'b0}}, entry_ff.len};
      s_end = {1'b0, seg.off} + {{(OFF_W-LEN_W+1){1'b0}}, seg.len};
      flags_in.hit   = ctrl.occupied && ({1'b0, seg.off} < e_end);
      flags_in.ahead = s_end <= {1'b0, entry_ff.off};
      flags_in.same  = seg.off == entry_ff.off;
   end

   always_comb begin
      entry_in = entry_ff;
      case (ctrl.action)
         CELL_LOAD:    entry_in = seg;
         CELL_SHIFT:   entry_in = prev_entry;
         CELL_SET_LEN: entry_in.len = seg.len;
         CELL_ROTATE:  entry_in = next_entry;
         default:      entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      flags_ff <= flags_in;
   end

   assign entry = entry_ff;
   assign flags = flags_ff;

endmodule

/* src/srt_gap_walk.sv */
// running offset tracker that finds holes as entries pass the chain head
module srt_gap_walk
   import srt_pkg::*;
(
   input  logic             clock,
   input  logic             clear,
   input  logic             step,
   input  entry_type        head,
   output logic             gap_fire,
   output logic [GAP_W-1:0] gap_offset,
   output logic [GAP_W-1:0] gap_length
);

   logic [OFF_W:0] run_ff, run_in;
   logic [OFF_W:0] e_off;
   logic [OFF_W:0] e_end;
   logic           at_run;
   logic           past_run;

   always_comb begin
      e_off    = {1'b0, head.off};
      e_end    = e_off + {{(OFF_W-LEN_W+1){1'b0}}, head.len};
      at_run   = run_ff == e_off;
      past_run = run_ff < e_off;
      gap_fire = step && past_run;
      run_in   = run_ff;
      if (clear) begin
         run_in = '0;
      end else if (step && (at_run || past_run)) begin
         run_in = e_end;
      end
   end

   // run is below a 32-bit offset whenever a gap fires
   assign gap_offset = run_ff[GAP_W-1:0];
   assign gap_length = head.off - run_ff[OFF_W-1:0];

   always_ff @(posedge clock) begin
      run_ff <= run_in;
   end

endmodule

/* src/segment_reassembly_tracker_unit.sv */
// top level of the segment reassembly tracker: control, cell chain and result register
//
// A transaction is accepted when start is high and busy is low; busy stays high until the
// block can take the next one. Each entry of the table lives in a cell of a chain. A segment
// transaction runs in order: the segment is captured, every cell compares it with its entry,
// then the first cell hit decides insert, replace, overlap or full unless an early drop
// verdict stands, and an insert shifts the cells behind it one place down the chain. Its
// single result appears in the cycle after that decision. A scan transaction rotates the
// whole ring of TABLE_DEPTH cells once past the head, one cell a cycle, then gives the end
// marker; gap results come out in the cycle after their entry reaches the head, and the end
// marker comes from the end state after the last rotation step. Results are shown for one
// cycle with rsp_valid and cannot be held off. No clearing pass is needed after reset: only
// entries below the entry count are ever looked at. Register writes leave the table alone.
module segment_reassembly_tracker_unit
   import srt_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic             req_op,
   input  logic [OFF_W-1:0] req_seg_offset,
   input  logic [LEN_W-1:0] req_seg_length,
   input  logic [15:0]      req_seg_file_id,
   input  logic             req_seg_is_payload,
   input  logic             req_crc_good,
   output logic             rsp_valid,
   output logic [2:0]       rsp_status,
   output logic [GAP_W-1:0] rsp_gap_offset,
   output logic [GAP_W-1:0] rsp_gap_length,
   output logic             rsp_last,
   input  logic             csr_write_en,
   input  logic             csr_index,
   input  logic [15:0]      csr_wdata
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int IW = $clog2(TABLE_DEPTH);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_CMP   = 5'b00010,
      S_PLACE = 5'b00100,
      S_SCAN  = 5'b01000,
      S_END   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [15:0] file_id_ff;
   logic        file_active_ff;

   // captured segment and its early verdict
   entry_type   seg_ff, seg_in;
   logic        drop_ff, drop_in;
   logic [2:0]  drop_status_ff, drop_status_in;

   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] step_ff, step_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_status_ff, rsp_status_in;
   logic [GAP_W-1:0] rsp_gap_offset_ff, rsp_gap_offset_in;
   logic [GAP_W-1:0] rsp_gap_length_ff, rsp_gap_length_in;
   logic             rsp_last_ff, rsp_last_in;

   cell_ctrl_type  cell_ctrl  [TABLE_DEPTH];
   cell_flags_type cell_flags [TABLE_DEPTH];
   entry_type      cell_entry [TABLE_DEPTH];

   logic             accept;
   logic             table_full;
   logic             scan_step;
   logic             gap_fire;
   logic [GAP_W-1:0] gap_offset;
   logic [GAP_W-1:0] gap_length;

   // placement decision terms
   logic [TABLE_DEPTH-1:0] first_hit;
   logic [TABLE_DEPTH-1:0] behind_hit;
   logic [TABLE_DEPTH-1:0] occupied;
   logic                   any_hit;
   logic                   hit_before;
   logic                   hit_same;

   assign accept     = start && (state_ff == S_IDLE);
   assign busy       = state_ff != S_IDLE;
   assign table_full = count_ff == CW'(TABLE_DEPTH);
   assign scan_step  = (state_ff == S_SCAN) && (CW'(step_ff) < count_ff);

   // ---- cell chain: inserts pull from the cell in front, a scan rotation from the cell
   // ---- behind, with cell 0 wrapping round to the tail
   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      srt_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl[g]),
         .seg        (seg_ff),
         .prev_entry (cell_entry[(g + TABLE_DEPTH - 1) % TABLE_DEPTH]),
         .next_entry (cell_entry[(g + 1) % TABLE_DEPTH]),
         .entry      (cell_entry[g]),
         .flags      (cell_flags[g])
      );
   end

   srt_gap_walk u_gap_walk (
      .clock      (clock),
      .clear      (accept),
      .step       (scan_step),
      .head       (cell_entry[0]),
      .gap_fire   (gap_fire),
      .gap_offset (gap_offset),
      .gap_length (gap_length)
   );

   // ---- first cell whose entry the segment does not lie wholly past ----
   always_comb begin
      logic seen;
      seen       = 1'b0;
      hit_before = 1'b0;
      hit_same   = 1'b0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         occupied[i]   = CW'(i) < count_ff;
         behind_hit[i] = seen;
         first_hit[i]  = cell_flags[i].hit && !seen;
         hit_before    = hit_before || (first_hit[i] && cell_flags[i].ahead);
         hit_same      = hit_same || (first_hit[i] && cell_flags[i].same);
         seen          = seen || cell_flags[i].hit;
      end
      any_hit = seen;
   end

   // ---- control ----
   always_comb begin
      state_in          = state_ff;
      seg_in            = seg_ff;
      drop_in           = drop_ff;
      drop_status_in    = drop_status_ff;
      count_in          = count_ff;
      step_in           = step_ff;
      rsp_valid_in      = 1'b0;
      rsp_status_in     = rsp_status_ff;
      rsp_gap_offset_in = '0;
      rsp_gap_length_in = '0;
      rsp_last_in       = 1'b0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         cell_ctrl[i].action   = CELL_HOLD;
         cell_ctrl[i].occupied = occupied[i];
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               seg_in.off = req_seg_offset;
               seg_in.len = req_seg_length;
               step_in    = '0;
               // crc is checked ahead of ownership
               drop_in        = !req_crc_good || !file_active_ff ||
                                (req_seg_file_id != file_id_ff) || !req_seg_is_payload;
               drop_status_in = !req_crc_good ? STATUS_BAD_CRC : STATUS_FOREIGN;
               state_in       = req_op ? S_SCAN : S_CMP;
            end
         end
         S_CMP: begin
            // cells register their compare flags this cycle
            state_in = S_PLACE;
         end
         S_PLACE: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = 1'b1;
            state_in     = S_IDLE;
            if (drop_ff) begin
               rsp_status_in = drop_status_ff;
            end else if (any_hit && !hit_before && hit_same) begin
               rsp_status_in = STATUS_REPLACED;
               for (int i = 0; i < TABLE_DEPTH; i++) begin
                  if (first_hit[i]) begin
                     cell_ctrl[i].action = CELL_SET_LEN;
                  end
               end
            end else if (any_hit && !hit_before) begin
               rsp_status_in = STATUS_OVERLAP;
            end else if (table_full) begin
               rsp_status_in = STATUS_FULL;
            end else begin
               rsp_status_in = STATUS_INSERTED;
               count_in      = count_ff + CW'(1);
               for (int i = 0; i < TABLE_DEPTH; i++) begin
                  if (any_hit) begin
                     // insert ahead of the first hit, the rest moves down one cell
                     if (first_hit[i]) begin
                        cell_ctrl[i].action = CELL_LOAD;
                     end else if (behind_hit[i]) begin
                        cell_ctrl[i].action = CELL_SHIFT;
                     end
                  end else if (CW'(i) == count_ff) begin
                     // append after the last entry
                     cell_ctrl[i].action = CELL_LOAD;
                  end
               end
            end
         end
         S_SCAN: begin
            // rotate towards the head so entries reach cell 0 in offset order
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               cell_ctrl[i].action = CELL_ROTATE;
            end
            if (gap_fire) begin
               rsp_valid_in      = 1'b1;
               rsp_status_in     = STATUS_GAP;
               rsp_gap_offset_in = gap_offset;
               rsp_gap_length_in = gap_length;
            end
            step_in = step_ff + IW'(1);
            if (step_ff == IW'(TABLE_DEPTH - 1)) begin
               state_in = S_END;
            end
         end
         S_END: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_SCAN_END;
            rsp_last_in   = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         file_id_ff     <= '0;
         file_active_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_FILE_ID:     file_id_ff     <= csr_wdata;
               CSR_FILE_ACTIVE: file_active_ff <= csr_wdata[0];
               default:         file_active_ff <= file_active_ff;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      seg_ff            <= seg_in;
      drop_ff           <= drop_in;
      drop_status_ff    <= drop_status_in;
      step_ff           <= step_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_gap_offset_ff <= rsp_gap_offset_in;
      rsp_gap_length_ff <= rsp_gap_length_in;
      rsp_last_ff       <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_gap_offset = rsp_gap_offset_ff;
   assign rsp_gap_length = rsp_gap_length_ff;
   assign rsp_last       = rsp_last_ff;

   // ---- checks ----
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_last_when_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (state_ff == S_IDLE))
      else $error("final result while transaction still running");

   a_gap_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_GAP) |-> (!rsp_last_ff && rsp_gap_length_ff != '0))
      else $error("malformed gap result");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && count_ff != $past(count_ff)) |->
         ($past(state_ff) == S_PLACE && count_ff == CW'($past(count_ff) + CW'(1))))
      else $error("entry count moved outside an insert");

endmodule
